[src/ulcm_pkg.sv]
// ----------------------------------------------------------------------------
// ulcm_pkg - shared constants and helpers for the line command matcher
// Holds the beat opcodes, control byte codes, the fixed response words and
// the per-position character match function.
// ----------------------------------------------------------------------------
`default_nettype none

package ulcm_pkg;

  // beat opcodes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // control bytes
  localparam logic [7:0] BYTE_CR = 8'h0d;
  localparam logic [7:0] BYTE_LF = 8'h0a;
  localparam logic [7:0] BYTE_NUL = 8'h00;

  // latched index meaning no word
  localparam logic [2:0] NONE_INDEX = 3'd5;

  // word table geometry
  localparam int WORD_SLOTS = 5;
  localparam int WORD_CHARS = 10;
  localparam int CHAR_IDX_W = 4;
  // position argument wide enough for any supported line length
  localparam int POS_ARG_W = 7;

  localparam logic [7:0] WORD_TAB [WORD_SLOTS][WORD_CHARS] = '{
    '{"E", "r", "a", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"0", ",", "C", "O", "N", "N", "E", "C", "T", 8'h00},
    '{"0", ",", "C", "L", "O", "S", "E", "D", 8'h00, 8'h00},
    '{"E", "R", "R", "O", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"d", "e", "f", "a", "u", "l", "t", "5", 8'h00, 8'h00}
  };

  // bits of words whose character at position p equals b, past the end reads zero
  function automatic logic [WORD_SLOTS-1:0] words_with(input logic [POS_ARG_W-1:0] p,
                                                       input logic [7:0] b);
    logic [WORD_SLOTS-1:0] m;
    logic [7:0]            c;
    m = '0;
    for (int w = 0; w < WORD_SLOTS; w++) begin
      if (p < POS_ARG_W'(WORD_CHARS)) begin
        c = WORD_TAB[w][p[CHAR_IDX_W-1:0]];
      end else begin
        c = BYTE_NUL;
      end
      m[w] = (c == b);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[src/ulcm_in_if.sv]
// ----------------------------------------------------------------------------
// ulcm_in_if - input channel of the line command matcher
// Valid/ready channel carrying one opcode and one received byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ulcm_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

`default_nettype wire

[src/ulcm_out_if.sv]
// ----------------------------------------------------------------------------
// ulcm_out_if - result channel of the line command matcher
// Valid/ready channel carrying the latched index and match flags per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ulcm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] command_index;
  logic       matched_now;
  logic       transfer_seen;

  modport source (output valid, output command_index, output matched_now,
                  output transfer_seen, input ready);
  modport sink   (input valid, input command_index, input matched_now,
                  input transfer_seen, output ready);
endinterface

`default_nettype wire

[src/uart_line_command_matcher.sv]
// ----------------------------------------------------------------------------
// uart_line_command_matcher - received line matcher against fixed words
// Gathers received bytes into a line and, on carriage return, compares the
// line against the fixed response words with one alive bit per word.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one beat per received byte (op = byte) or per clear (op = clear).
//   rsp  : exactly one result beat per req beat, in order: latched command
//          index (5 = none), this-beat match flag, sticky transfer flag.
//   Every req beat updates the line state in the cycle it is taken and its
//   result sits in the output register from the next cycle, so throughput is
//   one beat per cycle while rsp does not stall. The rate is set by the
//   update of the alive bits and line position as each beat is taken.
//   req.ready is high while the output register is empty or being drained;
//   when rsp stalls with a result waiting, req stalls too and nothing is lost.
//   Reset (rst, synchronous) empties the output register, clears the alive
//   bits and position, drops the transfer flag and sets the index to none.
//   After reset no line holds a word, so a carriage return matches nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_line_command_matcher #(
  parameter int LINE_MAX  = 30,
  parameter int NUM_WORDS = 5
) (
  input  wire        clk,
  input  wire        rst,
  ulcm_in_if.sink    req,
  ulcm_out_if.source rsp
);

  localparam int USED  = (NUM_WORDS < ulcm_pkg::WORD_SLOTS) ? NUM_WORDS
                                                           : ulcm_pkg::WORD_SLOTS;
  localparam int POS_W = $clog2(LINE_MAX - 1);
  localparam int ARG_W = ulcm_pkg::POS_ARG_W;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_MAX - 2);
  localparam logic [USED-1:0]  USED_MASK = {USED{1'b1}};

  // line state
  logic [USED-1:0]  word_alive, word_alive_next;
  logic [POS_W-1:0] line_position, line_position_next;
  logic             line_terminated, line_terminated_next;
  logic [2:0]       latched_index, latched_index_next;
  logic             transfer_latch, transfer_latch_next;
  logic             hit;

  // output register
  logic             out_valid;
  logic [2:0]       out_index;
  logic             out_matched;
  logic             out_transfer;

  logic accept;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // per-beat update of the line and latches
  always_comb begin
    logic [USED-1:0]  full;
    logic [USED-1:0]  a;
    logic             t;
    logic [POS_W:0]   pinc;
    logic [ARG_W-1:0] parg;
    logic [ulcm_pkg::WORD_SLOTS-1:0] end_here;
    logic [ulcm_pkg::WORD_SLOTS-1:0] byte_here;
    logic [ulcm_pkg::WORD_SLOTS-1:0] end_after;
    parg = ARG_W'(line_position);
    pinc = {1'b0, line_position} + 1'b1;
    // word character matches at this slot and the one after it
    end_here  = ulcm_pkg::words_with(parg, ulcm_pkg::BYTE_NUL);
    byte_here = ulcm_pkg::words_with(parg, req.rx_byte);
    end_after = ulcm_pkg::words_with(ARG_W'(pinc), ulcm_pkg::BYTE_NUL);
    full = '0;
    a    = word_alive;
    t    = line_terminated;
    word_alive_next      = word_alive;
    line_position_next   = line_position;
    line_terminated_next = line_terminated;
    latched_index_next   = latched_index;
    transfer_latch_next  = transfer_latch;
    hit                  = 1'b0;
    if (req.op == ulcm_pkg::OP_CLEAR) begin
      latched_index_next = ulcm_pkg::NONE_INDEX;
    end else if (req.rx_byte == ulcm_pkg::BYTE_CR) begin
      // compare the whole line, lowest word index wins
      full = word_alive;
      if (!line_terminated) begin
        full = full & end_here[USED-1:0];
      end
      for (int w = USED - 1; w >= 0; w--) begin
        if (full[w]) begin
          latched_index_next = 3'(w);
        end
      end
      if (|full) begin
        hit                 = 1'b1;
        transfer_latch_next = 1'b1;
      end
    end else if (req.rx_byte == ulcm_pkg::BYTE_LF) begin
      // close the line at its current length
      if (!line_terminated) begin
        word_alive_next      = word_alive & end_here[USED-1:0];
        line_terminated_next = 1'b1;
      end
      line_position_next = '0;
    end else begin
      // ordinary byte, first one of a line restarts all words
      if (line_position == '0) begin
        a = USED_MASK;
        t = 1'b0;
      end
      if (!t) begin
        a = a & byte_here[USED-1:0];
        if (req.rx_byte == ulcm_pkg::BYTE_NUL) begin
          t = 1'b1;
        end
      end
      // wrap when the line is full
      if (line_position == POS_LAST) begin
        if (!t) begin
          a = a & end_after[USED-1:0];
          t = 1'b1;
        end
        line_position_next = '0;
      end else begin
        line_position_next = pinc[POS_W-1:0];
      end
      word_alive_next      = a;
      line_terminated_next = t;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      word_alive      <= '0;
      line_position   <= '0;
      line_terminated <= 1'b0;
      latched_index   <= ulcm_pkg::NONE_INDEX;
      transfer_latch  <= 1'b0;
    end else if (accept) begin
      word_alive      <= word_alive_next;
      line_position   <= line_position_next;
      line_terminated <= line_terminated_next;
      latched_index   <= latched_index_next;
      transfer_latch  <= transfer_latch_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_index    <= latched_index_next;
      out_matched  <= hit;
      out_transfer <= transfer_latch_next;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.command_index = out_index;
  assign rsp.matched_now   = out_matched;
  assign rsp.transfer_seen = out_transfer;

  // a match in a result always shows the sticky flag
  a_match_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_matched) |-> out_transfer)
    else $error("match without transfer flag");

  // line position never runs past the last slot
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    line_position <= POS_LAST)
    else $error("line position out of range");

  // a clear beat leaves no latched index
  a_clear_none: assert property (@(posedge clk) disable iff (rst)
    (accept && req.op == ulcm_pkg::OP_CLEAR) |=> (latched_index == ulcm_pkg::NONE_INDEX))
    else $error("clear did not reset index");

  // line feed returns to the start of the line and closes it
  a_lf_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && req.op == ulcm_pkg::OP_BYTE && req.rx_byte == ulcm_pkg::BYTE_LF)
    |=> (line_position == '0 && line_terminated))
    else $error("line feed did not restart line");

  // a waiting result holds while the sink stalls
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> (out_valid && $stable(out_index) && $stable(out_matched)))
    else $error("result changed under stall");

endmodule

`default_nettype wire
